// ----- rtl/lmd_pkg.sv -----
package lmd_pkg;

    localparam int MAX_SUBHEADERS = 16;
    localparam int IDX_W          = $clog2(MAX_SUBHEADERS);
    localparam int CNT_W          = IDX_W + 1;
    localparam int LEN_W          = 15;
    localparam int LEN_HI_W       = 7;
    localparam int CH_W           = 5;
    localparam int BYTE_W         = 8;

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        HP_TYPE,
        HP_LEN,
        HP_LEN_LO
    } t_hpos;

    typedef enum logic [2:0] {
        ST_DATA        = 3'd0,
        ST_TOO_MANY    = 3'd1,
        ST_HDR_CUT     = 3'd2,
        ST_PAY_CUT     = 3'd3,
        ST_EMPTY_FINAL = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  sdu_number;
        logic [CH_W-1:0]   channel_id;
        logic              last_of_sdu;
        logic              last_of_pdu;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  ch;
        logic [LEN_W-1:0] len;
    } t_tbl_wr;

    // search window: entries from .from up to, not including, .last
    typedef struct packed {
        logic [IDX_W-1:0] from;
        logic [IDX_W-1:0] last;
    } t_pick_req;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  ch;
        logic [LEN_W-1:0] len;
    } t_pick_rsp;

endpackage

// ----- rtl/lmd_subhdr_table.sv -----
module lmd_subhdr_table (
    input  logic               i_clk,
    input  lmd_pkg::t_tbl_wr   i_wr,
    input  lmd_pkg::t_pick_req i_req,
    output lmd_pkg::t_pick_rsp o_rsp
);

    logic [lmd_pkg::CH_W-1:0]  r_ch  [lmd_pkg::MAX_SUBHEADERS];
    logic [lmd_pkg::LEN_W-1:0] r_len [lmd_pkg::MAX_SUBHEADERS];
    logic [lmd_pkg::MAX_SUBHEADERS-1:0] r_nz;

    logic [lmd_pkg::MAX_SUBHEADERS-1:0] cand;
    logic                               found;
    logic [lmd_pkg::IDX_W-1:0]          hit;
    logic [lmd_pkg::IDX_W-1:0]          sel;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ch[i_wr.idx]  <= i_wr.ch;
            r_len[i_wr.idx] <= i_wr.len;
            r_nz[i_wr.idx]  <= (i_wr.len != '0);
        end
    end

    // window mask, then lowest set bit wins
    always_comb begin
        for (int j = 0; j < lmd_pkg::MAX_SUBHEADERS; j++) begin
            cand[j] = r_nz[j] && (lmd_pkg::IDX_W'(j) >= i_req.from)
                      && (lmd_pkg::IDX_W'(j) < i_req.last);
        end
    end

    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int j = lmd_pkg::MAX_SUBHEADERS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                found = 1'b1;
                hit   = lmd_pkg::IDX_W'(j);
            end
        end
    end

    assign sel         = found ? hit : i_req.last;
    assign o_rsp.found = found;
    assign o_rsp.idx   = sel;
    assign o_rsp.ch    = r_ch[sel];
    assign o_rsp.len   = found ? r_len[sel] : '0;

endmodule

// ----- rtl/lmd_parser.sv -----
module lmd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [lmd_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_eop,
    input  lmd_pkg::t_pick_rsp          i_pick,
    output lmd_pkg::t_pick_req          o_pick,
    output lmd_pkg::t_tbl_wr            o_wr,
    output logic                        o_res_valid,
    output lmd_pkg::t_result            o_res
);

    lmd_pkg::t_phase                r_phase,    n_phase;
    lmd_pkg::t_hpos                 r_pos,      n_pos;
    logic [lmd_pkg::CH_W-1:0]       r_pend_ch,  n_pend_ch;
    logic                           r_long,     n_long;
    logic [lmd_pkg::LEN_HI_W-1:0]   r_len_hi,   n_len_hi;
    logic [lmd_pkg::CNT_W-1:0]      r_count,    n_count;
    logic [lmd_pkg::IDX_W-1:0]      r_cur,      n_cur;
    logic [lmd_pkg::CH_W-1:0]       r_cur_ch,   n_cur_ch;
    logic [lmd_pkg::LEN_W-1:0]      r_left,     n_left;
    logic                           r_err,      n_err;

    logic [lmd_pkg::CH_W-1:0]  lcid;
    logic                      ext;
    logic                      full;
    logic                      cur_final;
    logic [lmd_pkg::LEN_W-1:0] left_dec;
    logic                      done;
    logic                      commit;
    logic [lmd_pkg::CNT_W-1:0] cnt_after;
    logic [lmd_pkg::CH_W-1:0]  first_ch;

    assign lcid      = i_byte[lmd_pkg::CH_W-1:0];
    assign ext       = i_byte[lmd_pkg::CH_W];
    assign full      = r_count >= lmd_pkg::CNT_W'(lmd_pkg::MAX_SUBHEADERS);
    assign cur_final = ({1'b0, r_cur} + lmd_pkg::CNT_W'(1)) >= r_count;
    assign left_dec  = (r_left != '0) ? r_left - lmd_pkg::LEN_W'(1) : r_left;
    assign done      = (left_dec == '0);
    // the final subheader is written in the same cycle it is looked up
    assign first_ch  = i_pick.found ? i_pick.ch : lcid;

    assign commit = !r_err && (r_phase == lmd_pkg::PH_HEADER) &&
                    (((r_pos == lmd_pkg::HP_TYPE) && !full && !ext) ||
                     ((r_pos == lmd_pkg::HP_LEN) && !i_byte[lmd_pkg::BYTE_W-1]) ||
                     (r_pos == lmd_pkg::HP_LEN_LO));
    assign cnt_after = r_count + lmd_pkg::CNT_W'(commit);

    // header: search all earlier SDUs; payload: those after the current one, before the final one
    always_comb begin
        if (r_phase == lmd_pkg::PH_HEADER) begin
            o_pick.from = '0;
            o_pick.last = r_count[lmd_pkg::IDX_W-1:0];
        end else begin
            o_pick.from = r_cur + lmd_pkg::IDX_W'(1);
            o_pick.last = r_count[lmd_pkg::IDX_W-1:0] - lmd_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        o_wr.en  = i_valid && commit;
        o_wr.idx = r_count[lmd_pkg::IDX_W-1:0];
        o_wr.ch  = (r_pos == lmd_pkg::HP_TYPE) ? lcid : r_pend_ch;
        unique case (r_pos)
            lmd_pkg::HP_TYPE: o_wr.len = '0;
            lmd_pkg::HP_LEN:  o_wr.len = lmd_pkg::LEN_W'(i_byte[lmd_pkg::LEN_HI_W-1:0]);
            default:          o_wr.len = {r_len_hi, i_byte};
        endcase
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_pend_ch = r_pend_ch;
        n_long    = r_long;
        n_len_hi  = r_len_hi;
        n_count   = cnt_after;
        n_cur     = r_cur;
        n_cur_ch  = r_cur_ch;
        n_left    = r_left;
        n_err     = r_err;
        if (commit) begin
            n_pos  = lmd_pkg::HP_TYPE;
            n_long = 1'b0;
        end
        if (r_err) begin
            // drop until end of PDU
        end else if (r_phase == lmd_pkg::PH_HEADER) begin
            unique case (r_pos)
                lmd_pkg::HP_TYPE: begin
                    if (full) begin
                        n_err = !i_eop;
                    end else if (!ext) begin
                        n_pend_ch = lcid;
                        n_phase   = lmd_pkg::PH_PAYLOAD;
                        n_cur     = i_pick.idx;
                        n_cur_ch  = first_ch;
                        n_left    = i_pick.len;
                    end else begin
                        n_pend_ch = lcid;
                        n_pos     = lmd_pkg::HP_LEN;
                    end
                end
                lmd_pkg::HP_LEN: begin
                    if (i_byte[lmd_pkg::BYTE_W-1]) begin
                        n_long   = 1'b1;
                        n_len_hi = i_byte[lmd_pkg::LEN_HI_W-1:0];
                        n_pos    = lmd_pkg::HP_LEN_LO;
                    end
                end
                default: begin
                end
            endcase
        end else if (!cur_final) begin
            n_left = left_dec;
            if (done) begin
                n_cur    = i_pick.idx;
                n_cur_ch = i_pick.ch;
                n_left   = i_pick.len;
            end
        end
        // any end of PDU, and any header error, starts a fresh PDU
        if (i_eop || (!r_err && r_phase == lmd_pkg::PH_HEADER &&
                      r_pos == lmd_pkg::HP_TYPE && full)) begin
            n_phase   = lmd_pkg::PH_HEADER;
            n_pos     = lmd_pkg::HP_TYPE;
            n_pend_ch = '0;
            n_long    = 1'b0;
            n_len_hi  = '0;
            n_count   = '0;
            n_cur     = '0;
            n_left    = '0;
            if (i_eop) begin
                n_err = 1'b0;
            end
        end
    end

    // result
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.payload_byte = '0;
        o_res.sdu_number   = r_cur;
        o_res.channel_id   = r_cur_ch;
        o_res.last_of_sdu  = 1'b0;
        o_res.last_of_pdu  = 1'b1;
        o_res.status       = lmd_pkg::ST_DATA;
        if (r_err) begin
            o_res_valid = 1'b0;
        end else if (r_phase == lmd_pkg::PH_HEADER) begin
            if ((r_pos == lmd_pkg::HP_TYPE) && full) begin
                o_res_valid      = 1'b1;
                o_res.sdu_number = '0;
                o_res.channel_id = lcid;
                o_res.status     = lmd_pkg::ST_TOO_MANY;
            end else if ((r_pos == lmd_pkg::HP_TYPE) && !ext) begin
                o_res_valid       = i_eop;
                o_res.sdu_number  = i_pick.idx;
                o_res.channel_id  = first_ch;
                o_res.last_of_sdu = !i_pick.found;
                o_res.status      = i_pick.found ? lmd_pkg::ST_PAY_CUT
                                                 : lmd_pkg::ST_EMPTY_FINAL;
            end else begin
                o_res_valid      = i_eop;
                o_res.sdu_number = cnt_after[lmd_pkg::IDX_W-1:0];
                o_res.channel_id = (r_pos == lmd_pkg::HP_TYPE) ? lcid : r_pend_ch;
                o_res.status     = lmd_pkg::ST_HDR_CUT;
            end
        end else if (cur_final) begin
            o_res_valid        = 1'b1;
            o_res.payload_byte = i_byte;
            o_res.last_of_sdu  = i_eop;
            o_res.last_of_pdu  = i_eop;
        end else if (i_eop) begin
            o_res_valid = 1'b1;
            if (done && !i_pick.found) begin
                o_res.payload_byte = i_byte;
                o_res.last_of_sdu  = 1'b1;
            end else begin
                o_res.status = lmd_pkg::ST_PAY_CUT;
            end
        end else begin
            o_res_valid        = 1'b1;
            o_res.payload_byte = i_byte;
            o_res.last_of_sdu  = done;
            o_res.last_of_pdu  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lmd_pkg::PH_HEADER;
            r_pos     <= lmd_pkg::HP_TYPE;
            r_pend_ch <= '0;
            r_long    <= 1'b0;
            r_len_hi  <= '0;
            r_count   <= '0;
            r_cur     <= '0;
            r_cur_ch  <= '0;
            r_left    <= '0;
            r_err     <= 1'b0;
        end else if (i_valid) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_pend_ch <= n_pend_ch;
            r_long    <= n_long;
            r_len_hi  <= n_len_hi;
            r_count   <= n_count;
            r_cur     <= n_cur;
            r_cur_ch  <= n_cur_ch;
            r_left    <= n_left;
            r_err     <= n_err;
        end
    end

endmodule

// ----- rtl/lte_mac_pdu_deframer.sv -----
// MAC PDU deframer.
// Slave stream: one PDU byte per transaction, tlast on the final byte of a
// PDU. The block parses the R/R/E/LCID subheaders (with F and a 7- or 15-bit
// length while E is set), stores up to sixteen of them, then emits every
// payload byte on the master stream tagged with SDU number and LCID.
// Empty SDUs before the final one are skipped; the final SDU takes the rest
// of the PDU. Header bytes give no output, except for the status cases below.
// Errors (too many subheaders, header cut short, payload cut short) and an
// empty final SDU give one status transaction with tlast set; after an error
// the rest of the PDU is dropped silently up to its tlast.
// A byte accepted into the input register is parsed from there once the
// output register can take its result, which then waits there with tvalid
// high until it is taken. Throughput: one byte per cycle while the receiver
// does not stall, set by the combinational parse step with its priority
// pick over the subheader table.
// Reset (synchronous, active low) returns the parser to the first subheader
// of a new PDU and empties both stages.
// When the receiver stalls, the result waits in the output register and one
// more byte is taken into the input register; tready then drops until the
// result is taken.
module lte_mac_pdu_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_pdu
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] payload_byte, [11:8] sdu_number,
                                          // [16:12] channel_id, [23:17] zero
    output logic        o_m_axis_tlast,   // last_of_pdu
    output logic [3:0]  o_m_axis_tuser    // [0] last_of_sdu, [3:1] status
);

    logic                         r_in_valid;
    logic [lmd_pkg::BYTE_W-1:0]   r_in_byte;
    logic                         r_in_eop;
    logic                         r_out_valid;
    lmd_pkg::t_result             r_out;

    logic                         advance;
    logic                         res_valid;
    lmd_pkg::t_result             res;
    lmd_pkg::t_pick_req           pick_req;
    lmd_pkg::t_pick_rsp           pick_rsp;
    lmd_pkg::t_tbl_wr             tbl_wr;

    // the parse step runs whenever a byte waits in the input register and the output register can take its result
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eop  <= i_s_axis_tlast;
        end
    end

    lmd_subhdr_table u_table (
        .i_clk (i_clk),
        .i_wr  (tbl_wr),
        .i_req (pick_req),
        .o_rsp (pick_rsp)
    );

    lmd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_byte      (r_in_byte),
        .i_eop       (r_in_eop),
        .i_pick      (pick_rsp),
        .o_pick      (pick_req),
        .o_wr        (tbl_wr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.channel_id, r_out.sdu_number, r_out.payload_byte};
    assign o_m_axis_tlast  = r_out.last_of_pdu;
    assign o_m_axis_tuser  = {r_out.status, r_out.last_of_sdu};

endmodule
